>>> hw/rtl/irpe_pkg.sv
// ----------------------------------------------------------------------------
// irpe_pkg
// Shared types and constants of the infrared pulse train encoder.
// ----------------------------------------------------------------------------
package irpe_pkg;

  // default sizing
  localparam int MAX_BITS_DEF  = 32;
  localparam int TIME_BITS_DEF = 16;

  // fixed field widths
  localparam int CODE_W   = 32;
  localparam int OUT_W    = 17;
  localparam int CNT_W    = 6;
  localparam int CFG_IX_W = 3;
  localparam int CFG_D_W  = 64;
  localparam int SLOT_W   = 16;

  // protocol modes
  typedef enum logic [1:0] {
    MODE_PDIST = 2'd0,
    MODE_PLEN  = 2'd1,
    MODE_MANCH = 2'd2
  } mode_t;

  // configuration register indexes
  typedef enum logic [CFG_IX_W-1:0] {
    CFG_PROTOCOL_MODE  = 3'd0,
    CFG_BIT_COUNT      = 3'd1,
    CFG_LSB_FIRST      = 3'd2,
    CFG_HEADER_TIMES   = 3'd3,
    CFG_BIT_PULSE_TIME = 3'd4,
    CFG_BIT_SPACE      = 3'd5,
    CFG_TRAILER_PULSE  = 3'd6,
    CFG_MANCH_TIMES    = 3'd7
  } cfg_index_t;

  // register reset values
  localparam logic [1:0]  RST_PROTOCOL_MODE = 2'd0;
  localparam logic [5:0]  RST_BIT_COUNT     = 6'd4;
  localparam logic        RST_LSB_FIRST     = 1'b0;
  localparam logic [31:0] RST_HEADER_TIMES  = 32'd122882125;
  localparam logic [15:0] RST_BIT_PULSE     = 16'd625;
  localparam logic [31:0] RST_BIT_SPACE     = 32'd106496375;
  localparam logic [15:0] RST_TRAILER_PULSE = 16'd625;
  localparam logic [63:0] RST_MANCH_TIMES   = 64'd249953593308218232;

  // classified item as it travels from front to back
  typedef struct packed {
    logic [1:0]       mode;
    logic [CNT_W-1:0] bits;
  } ctrl_t;

endpackage

>>> hw/rtl/irpe_queue.sv
// ----------------------------------------------------------------------------
// irpe_queue
// Two-entry register queue between the classifier and the pair sequencer.
// ----------------------------------------------------------------------------
module irpe_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] data_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;
  logic         push;
  logic         pop;

  // occupancy flags
  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_data  = data_r[rd_ptr_r];
  assign push      = push_valid && !full;
  assign pop       = pop_valid && pop_ready;

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) data_r[wr_ptr_r] <= push_data;
  end

endmodule

>>> hw/rtl/irpe_front.sv
// ----------------------------------------------------------------------------
// irpe_front
// Accepts scancodes, drops the reserved mode and puts the bits in send order.
// ----------------------------------------------------------------------------
module irpe_front #(
  parameter int MAX_BITS = irpe_pkg::MAX_BITS_DEF
) (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [irpe_pkg::CODE_W-1:0] in_scancode,
  input  logic [1:0]                  cfg_mode,
  input  logic [irpe_pkg::CNT_W-1:0]  cfg_bit_count,
  input  logic                        cfg_lsb_first,
  input  logic                        q_full,
  output logic                        q_push,
  output irpe_pkg::ctrl_t             q_ctrl,
  output logic [MAX_BITS-1:0]         q_seq
);

  localparam logic [irpe_pkg::CNT_W-1:0] MaxCnt = irpe_pkg::CNT_W'(MAX_BITS);

  logic [MAX_BITS-1:0]        code_m;
  logic [MAX_BITS-1:0]        code_rev;
  logic [irpe_pkg::CNT_W-1:0] bits;
  logic [irpe_pkg::CNT_W-1:0] shamt;
  logic                       mode_ok;
  logic                       manch;

  // mode classification
  assign manch   = (cfg_mode == irpe_pkg::MODE_MANCH);
  assign mode_ok = (cfg_mode == irpe_pkg::MODE_PDIST) ||
                   (cfg_mode == irpe_pkg::MODE_PLEN) || manch;

  // bit count saturation
  assign bits  = (cfg_bit_count > MaxCnt) ? MaxCnt : cfg_bit_count;
  assign shamt = MaxCnt - bits;

  // bit order: first bit sent ends up at the top of the word
  assign code_m = in_scancode[MAX_BITS-1:0];
  always_comb begin
    for (int i = 0; i < MAX_BITS; i++) begin
      code_rev[i] = code_m[MAX_BITS-1-i];
    end
  end

  assign q_seq = (cfg_lsb_first && !manch) ? code_rev : (code_m << shamt);

  // queue push; reserved mode is taken and discarded
  assign in_stall    = q_full;
  assign q_push      = in_valid && !q_full && mode_ok;
  assign q_ctrl.mode = cfg_mode;
  assign q_ctrl.bits = bits;

endmodule

>>> hw/rtl/irpe_back.sv
// ----------------------------------------------------------------------------
// irpe_back
// Pair sequencer: walks header, bits and tail, at most one pair a cycle.
// ----------------------------------------------------------------------------
module irpe_back #(
  parameter int MAX_BITS  = irpe_pkg::MAX_BITS_DEF,
  parameter int TIME_BITS = irpe_pkg::TIME_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  irpe_pkg::ctrl_t            q_ctrl,
  input  logic [MAX_BITS-1:0]        q_seq,
  input  logic [31:0]                cfg_header_times,
  input  logic [15:0]                cfg_bit_pulse_time,
  input  logic [31:0]                cfg_bit_space_times,
  input  logic [15:0]                cfg_trailer_pulse_time,
  input  logic [63:0]                cfg_manchester_times,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [irpe_pkg::OUT_W-1:0] out_pulse_us,
  output logic [irpe_pkg::OUT_W-1:0] out_space_us,
  output logic                       out_last_pair
);

  localparam int AW = TIME_BITS + 1;
  localparam int OW = irpe_pkg::OUT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_BITS,
    ST_TAIL
  } state_t;

  state_t                     state_r, state_nxt;
  logic [1:0]                 mode_r, mode_nxt;
  logic [irpe_pkg::CNT_W-1:0] rem_r, rem_nxt;
  logic [MAX_BITS-1:0]        seq_r, seq_nxt;
  logic [AW-1:0]              p_acc_r, p_acc_nxt;
  logic [AW-1:0]              s_acc_r, s_acc_nxt;
  logic                       has_sp_r, has_sp_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [OW-1:0]              out_pulse_r, out_pulse_nxt;
  logic [OW-1:0]              out_space_r, out_space_nxt;
  logic                       out_last_r, out_last_nxt;

  logic [TIME_BITS-1:0] hdr_p, hdr_s, bit_p, trl_p, sp_zero, sp_one, sp_bit;
  logic [TIME_BITS-1:0] m_one_p, m_one_s, m_zero_s, m_zero_p;
  logic                 out_free;
  logic                 cur_bit;
  logic                 need_emit;
  logic [AW-1:0]        s_merge;
  logic                 is_pdist, is_plen;

  // time slots, each masked to the time width
  assign hdr_p    = TIME_BITS'(cfg_header_times);
  assign hdr_s    = TIME_BITS'(cfg_header_times >> irpe_pkg::SLOT_W);
  assign bit_p    = TIME_BITS'(cfg_bit_pulse_time);
  assign trl_p    = TIME_BITS'(cfg_trailer_pulse_time);
  assign sp_zero  = TIME_BITS'(cfg_bit_space_times);
  assign sp_one   = TIME_BITS'(cfg_bit_space_times >> irpe_pkg::SLOT_W);
  assign m_one_p  = TIME_BITS'(cfg_manchester_times);
  assign m_one_s  = TIME_BITS'(cfg_manchester_times >> irpe_pkg::SLOT_W);
  assign m_zero_s = TIME_BITS'(cfg_manchester_times >> (2 * irpe_pkg::SLOT_W));
  assign m_zero_p = TIME_BITS'(cfg_manchester_times >> (3 * irpe_pkg::SLOT_W));

  assign cur_bit  = seq_r[MAX_BITS-1];
  assign sp_bit   = cur_bit ? sp_one : sp_zero;
  assign out_free = !out_valid_r || !out_stall;
  assign is_pdist = (mode_r == irpe_pkg::MODE_PDIST);
  assign is_plen  = (mode_r == irpe_pkg::MODE_PLEN);
  assign s_merge  = has_sp_r ? (s_acc_r + AW'(m_zero_s)) : AW'(m_zero_s);

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    rem_nxt       = rem_r;
    seq_nxt       = seq_r;
    p_acc_nxt     = p_acc_r;
    s_acc_nxt     = s_acc_r;
    has_sp_nxt    = has_sp_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pulse_nxt = out_pulse_r;
    out_space_nxt = out_space_r;
    out_last_nxt  = out_last_r;
    q_ready       = 1'b0;
    need_emit     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          mode_nxt   = q_ctrl.mode;
          rem_nxt    = q_ctrl.bits;
          seq_nxt    = q_seq;
          p_acc_nxt  = '0;
          s_acc_nxt  = '0;
          has_sp_nxt = 1'b0;
          if (q_ctrl.mode != irpe_pkg::MODE_MANCH) begin
            state_nxt = ST_HEAD;
          end else if (q_ctrl.bits == '0) begin
            state_nxt = ST_TAIL;
          end else begin
            state_nxt = ST_BITS;
          end
        end
      end

      ST_HEAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pulse_nxt = OW'(hdr_p);
          out_space_nxt = OW'(hdr_s);
          out_last_nxt  = is_plen && (rem_r == '0);
          if (rem_r != '0) begin
            state_nxt = ST_BITS;
          end else begin
            state_nxt = is_pdist ? ST_TAIL : ST_IDLE;
          end
        end
      end

      ST_BITS: begin
        // pair content for this bit
        priority if (is_pdist) begin
          need_emit     = 1'b1;
          out_pulse_nxt = OW'(bit_p);
          out_space_nxt = OW'(sp_bit);
          out_last_nxt  = 1'b0;
        end else if (is_plen) begin
          need_emit     = 1'b1;
          out_pulse_nxt = OW'(sp_bit);
          out_space_nxt = OW'(bit_p);
          out_last_nxt  = (rem_r == 1);
        end else if (cur_bit) begin
          // one: pulse half then space half
          need_emit     = has_sp_r;
          out_pulse_nxt = OW'(p_acc_r);
          out_space_nxt = OW'(s_acc_r);
          out_last_nxt  = 1'b0;
        end else begin
          // zero: space half then pulse half, closes the pair
          need_emit     = 1'b1;
          out_pulse_nxt = OW'(p_acc_r);
          out_space_nxt = OW'(s_merge);
          out_last_nxt  = 1'b0;
        end

        if (!need_emit || out_free) begin
          if (need_emit) out_valid_nxt = 1'b1;
          else begin
            out_pulse_nxt = out_pulse_r;
            out_space_nxt = out_space_r;
            out_last_nxt  = out_last_r;
          end
          // manchester running halves
          if (cur_bit) begin
            p_acc_nxt  = has_sp_r ? AW'(m_one_p) : (p_acc_r + AW'(m_one_p));
            s_acc_nxt  = AW'(m_one_s);
            has_sp_nxt = 1'b1;
          end else begin
            p_acc_nxt  = AW'(m_zero_p);
            s_acc_nxt  = s_merge;
            has_sp_nxt = 1'b0;
          end
          seq_nxt = seq_r << 1;
          rem_nxt = rem_r - 1'b1;
          if (rem_r == 1) state_nxt = is_plen ? ST_IDLE : ST_TAIL;
        end else begin
          out_pulse_nxt = out_pulse_r;
          out_space_nxt = out_space_r;
          out_last_nxt  = out_last_r;
        end
      end

      ST_TAIL: begin
        // trailer pulse, or the last manchester pulse with its space dropped
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pulse_nxt = is_pdist ? OW'(trl_p) : OW'(p_acc_r);
          out_space_nxt = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r      <= mode_nxt;
    rem_r       <= rem_nxt;
    seq_r       <= seq_nxt;
    p_acc_r     <= p_acc_nxt;
    s_acc_r     <= s_acc_nxt;
    has_sp_r    <= has_sp_nxt;
    out_pulse_r <= out_pulse_nxt;
    out_space_r <= out_space_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_pulse_us  = out_pulse_r;
  assign out_space_us  = out_space_r;
  assign out_last_pair = out_last_r;

  // bit walk never runs with no bits left
  a_bits_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BITS) |-> (rem_r != '0))
    else $error("bit state with zero remaining bits");

  // header pair only for the header-based modes
  a_head_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HEAD) |-> (mode_r != irpe_pkg::MODE_MANCH))
    else $error("header state in manchester mode");

  // pulse-length trains end in the bit walk or the header, never at a tail
  a_tail_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TAIL) |-> (mode_r != irpe_pkg::MODE_PLEN))
    else $error("tail state in pulse-length mode");

  // tail hands out a final pair and goes idle
  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TAIL && out_free) |=>
      (state_r == ST_IDLE && out_valid_r && out_last_r && out_space_r == '0))
    else $error("tail did not close the train");

endmodule

>>> hw/rtl/ir_pulse_train_encoder_top.sv
// ----------------------------------------------------------------------------
// ir_pulse_train_encoder_top
// Infrared remote encoder: scancode in, pulse/space timing pairs out.
// ----------------------------------------------------------------------------
// One scancode yields the carrier timing train of the configured protocol
// (pulse distance, pulse length or manchester) as pulse/space pairs, at most
// one pair per cycle from the output register while out_stall is low. The
// sequencer picks the item from the two-entry queue, then sends the header
// pair (the manchester train has none), then walks the bits, then sends the
// trailer or the closing manchester pulse (pulse length has neither); a high
// out_stall holds the pair in the output register. Manchester bits that merge
// into the running half send nothing that cycle. Items in mode three are
// taken and give no pairs. The front takes a new scancode whenever the queue
// has room, so up to two items wait behind the train in progress.
// Configuration registers are to be written only while idle; the block
// itself does not enforce it.
module ir_pulse_train_encoder_top #(
  parameter int MAX_BITS  = irpe_pkg::MAX_BITS_DEF,
  parameter int TIME_BITS = irpe_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [irpe_pkg::CFG_IX_W-1:0] cfg_index,
  input  logic [irpe_pkg::CFG_D_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [irpe_pkg::CODE_W-1:0]   in_scancode,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [irpe_pkg::OUT_W-1:0]    out_pulse_us,
  output logic [irpe_pkg::OUT_W-1:0]    out_space_us,
  output logic                          out_last_pair
);

  localparam int QW = $bits(irpe_pkg::ctrl_t) + MAX_BITS;

  logic [1:0]                 protocol_mode_r;
  logic [irpe_pkg::CNT_W-1:0] bit_count_r;
  logic                       lsb_first_r;
  logic [31:0]                header_times_r;
  logic [15:0]                bit_pulse_time_r;
  logic [31:0]                bit_space_times_r;
  logic [15:0]                trailer_pulse_time_r;
  logic [63:0]                manchester_times_r;

  logic                q_full;
  logic                q_push;
  irpe_pkg::ctrl_t     f_ctrl;
  logic [MAX_BITS-1:0] f_seq;
  logic                q_valid;
  logic                q_ready;
  logic [QW-1:0]       q_data;
  irpe_pkg::ctrl_t     b_ctrl;
  logic [MAX_BITS-1:0] b_seq;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      protocol_mode_r      <= irpe_pkg::RST_PROTOCOL_MODE;
      bit_count_r          <= irpe_pkg::RST_BIT_COUNT;
      lsb_first_r          <= irpe_pkg::RST_LSB_FIRST;
      header_times_r       <= irpe_pkg::RST_HEADER_TIMES;
      bit_pulse_time_r     <= irpe_pkg::RST_BIT_PULSE;
      bit_space_times_r    <= irpe_pkg::RST_BIT_SPACE;
      trailer_pulse_time_r <= irpe_pkg::RST_TRAILER_PULSE;
      manchester_times_r   <= irpe_pkg::RST_MANCH_TIMES;
    end else if (cfg_wr_en) begin
      unique case (irpe_pkg::cfg_index_t'(cfg_index))
        irpe_pkg::CFG_PROTOCOL_MODE:  protocol_mode_r      <= cfg_wdata[1:0];
        irpe_pkg::CFG_BIT_COUNT:      bit_count_r          <= cfg_wdata[irpe_pkg::CNT_W-1:0];
        irpe_pkg::CFG_LSB_FIRST:      lsb_first_r          <= cfg_wdata[0];
        irpe_pkg::CFG_HEADER_TIMES:   header_times_r       <= cfg_wdata[31:0];
        irpe_pkg::CFG_BIT_PULSE_TIME: bit_pulse_time_r     <= cfg_wdata[15:0];
        irpe_pkg::CFG_BIT_SPACE:      bit_space_times_r    <= cfg_wdata[31:0];
        irpe_pkg::CFG_TRAILER_PULSE:  trailer_pulse_time_r <= cfg_wdata[15:0];
        irpe_pkg::CFG_MANCH_TIMES:    manchester_times_r   <= cfg_wdata;
      endcase
    end
  end

  // classifier
  irpe_front #(
    .MAX_BITS (MAX_BITS)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_scancode   (in_scancode),
    .cfg_mode      (protocol_mode_r),
    .cfg_bit_count (bit_count_r),
    .cfg_lsb_first (lsb_first_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_ctrl        (f_ctrl),
    .q_seq         (f_seq)
  );

  // decoupling queue
  irpe_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push),
    .push_data  ({f_ctrl, f_seq}),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign b_ctrl = q_data[QW-1:MAX_BITS];
  assign b_seq  = q_data[MAX_BITS-1:0];

  // pair sequencer
  irpe_back #(
    .MAX_BITS  (MAX_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_valid                (q_valid),
    .q_ready                (q_ready),
    .q_ctrl                 (b_ctrl),
    .q_seq                  (b_seq),
    .cfg_header_times       (header_times_r),
    .cfg_bit_pulse_time     (bit_pulse_time_r),
    .cfg_bit_space_times    (bit_space_times_r),
    .cfg_trailer_pulse_time (trailer_pulse_time_r),
    .cfg_manchester_times   (manchester_times_r),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_pulse_us           (out_pulse_us),
    .out_space_us           (out_space_us),
    .out_last_pair          (out_last_pair)
  );

endmodule
